### rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Default sizing of the frame table
  localparam int unsigned MAX_FRAMES_DEF = 8;
  localparam int unsigned PAGE_BITS_DEF  = 16;

  // Frame count register
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd3;

  // Running totals
  localparam int unsigned TOTAL_W = 16;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Outcome of one lookup in the frame table
  typedef struct packed {
    logic evict_valid;
    logic hit;
  } lru_status_t;

endpackage

### rtl/lru_frames.sv
// ----------------------------------------------------------------------------
// lru_frames
// Fully associative frame table with per-frame recency ranks. Looks up one
// page per cycle and, when enabled, applies the hit, fill or replacement.
// ----------------------------------------------------------------------------
module lru_frames
  import lru_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF,
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1),
  localparam int unsigned RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [CNT_W-1:0]     limit_i,
  output lru_status_t          status_o,
  output logic [PAGE_BITS-1:0] evicted_page_o
);

  logic [PAGE_BITS-1:0] page_q [MAX_FRAMES];
  logic [PAGE_BITS-1:0] page_d [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_q [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_d [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]     count_q, count_d;

  logic [MAX_FRAMES-1:0] match, victim, free_slot, slot;
  logic [RANK_W-1:0]     oldest_rank, hit_rank;
  logic [PAGE_BITS-1:0]  victim_page;
  logic                  hit, do_fill, do_evict;

  // Oldest resident page holds the rank one below the resident count
  assign oldest_rank = RANK_W'(count_q - CNT_W'(1));

  // Compare every frame at once; valid frames fill from index 0 upwards
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i]     = valid_q[i] && (page_q[i] == page_i);
      victim[i]    = valid_q[i] && (rank_q[i] == oldest_rank);
      free_slot[i] = (CNT_W'(i) == count_q);
    end
  end

  // Gather the rank of the hit frame and the page of the victim
  always_comb begin
    hit_rank    = '0;
    victim_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit_rank    = hit_rank | (rank_q[i] & {RANK_W{match[i]}});
      victim_page = victim_page | (page_q[i] & {PAGE_BITS{victim[i]}});
    end
  end

  assign hit      = |match;
  assign do_fill  = !hit && (count_q < limit_i);
  assign do_evict = !hit && !do_fill;

  always_comb begin
    priority if (hit) begin
      slot = match;
    end else if (do_fill) begin
      slot = free_slot;
    end else begin
      slot = victim;
    end
  end

  // Touched frame goes to rank 0; a hit ages more recent frames, a miss all
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      page_d[i]  = page_q[i];
      rank_d[i]  = rank_q[i];
      valid_d[i] = valid_q[i];
      if (slot[i]) begin
        rank_d[i]  = '0;
        valid_d[i] = 1'b1;
        if (!hit) begin
          page_d[i] = page_i;
        end
      end else if (valid_q[i] && (!hit || (rank_q[i] < hit_rank))) begin
        rank_d[i] = rank_q[i] + RANK_W'(1);
      end
    end
    count_d = count_q + CNT_W'(do_fill);
  end

  // Control state of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (en_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Page numbers held per frame
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        page_q[i] <= page_d[i];
      end
    end
  end

  assign status_o.hit         = hit;
  assign status_o.evict_valid = do_evict;
  assign evicted_page_o       = victim_page & {PAGE_BITS{do_evict}};

endmodule

### rtl/lru_page_replacement.sv
// A result is registered, in the output or skid register, when its reference
// is accepted. Throughput: one reference per cycle while the skid entry is
// empty, set by the compare of all frames and rank update in lru_frames.
// A two-entry output buffer keeps accepting while one result waits.
// Reset (asynchronous, active low) empties all frames, clears the totals and
// sets the frame count to 3.
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over a fully associative frame set, with running hit
// and fault totals, on stream interfaces.
// ----------------------------------------------------------------------------
module lru_page_replacement
  import lru_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF,
  localparam int unsigned IN_W  = ((PAGE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((PAGE_BITS + 2 * TOTAL_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: frames_in_use
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // Page references
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // page
  input  logic             s_axis_tlast,   // last_reference
  // Results
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // evicted_page, hit_total, fault_total
  output logic [1:0]       m_axis_tuser,   // hit, evict_valid
  output logic             m_axis_tlast    // final_flag
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LIM_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  logic [CFG_W-1:0]     cfg_q;
  logic [LIM_W-1:0]     cfg_ext, limit_ext;
  logic [CNT_W-1:0]     limit;
  logic                 accept;
  lru_status_t          status;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [TOTAL_W-1:0]   hit_total_q, hit_total_d, fault_total_q, fault_total_d;

  logic [OUT_W-1:0] res_data;
  logic [1:0]       res_user;
  logic [OUT_W-1:0] out_data_q, skid_data_q;
  logic [1:0]       out_user_q, skid_user_q;
  logic             out_last_q, skid_last_q;
  logic             out_valid_q, skid_valid_q;

  // Frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Clamp the frame count to 1..MAX_FRAMES
  assign cfg_ext = LIM_W'(cfg_q);
  always_comb begin
    priority if (cfg_ext == '0) begin
      limit_ext = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(MAX_FRAMES)) begin
      limit_ext = LIM_W'(MAX_FRAMES);
    end else begin
      limit_ext = cfg_ext;
    end
  end
  assign limit = CNT_W'(limit_ext);

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lru_frames #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (accept),
    .page_i         (s_axis_tdata[PAGE_BITS-1:0]),
    .limit_i        (limit),
    .status_o       (status),
    .evicted_page_o (evicted_page)
  );

  // Saturating totals
  always_comb begin
    hit_total_d   = hit_total_q;
    fault_total_d = fault_total_q;
    if (status.hit) begin
      if (hit_total_q != TOTAL_MAX) begin
        hit_total_d = hit_total_q + TOTAL_W'(1);
      end
    end else if (fault_total_q != TOTAL_MAX) begin
      fault_total_d = fault_total_q + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_total_q   <= '0;
      fault_total_q <= '0;
    end else if (accept) begin
      hit_total_q   <= hit_total_d;
      fault_total_q <= fault_total_d;
    end
  end

  // Pack the result transaction
  assign res_data = OUT_W'({fault_total_d, hit_total_d, evicted_page});
  assign res_user = {status.evict_valid, status.hit};

  // Output register with skid entry: park a result while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (out_valid_q && !m_axis_tready) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_data_q <= res_data;
        skid_user_q <= res_user;
        skid_last_q <= s_axis_tlast;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_user;
        out_last_q <= s_axis_tlast;
      end
    end else if (m_axis_tready && skid_valid_q) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
      out_last_q <= skid_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule
